// File: sv/quadratic_root_solver_core_macros.svh
// assertion helpers for the checker file
`ifndef QUADRATIC_ROOT_SOLVER_CORE_MACROS_SVH
`define QUADRATIC_ROOT_SOLVER_CORE_MACROS_SVH

// clocked assertion, disabled while reset is asserted
`define QRS_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);

// a result that waits on the port and is not taken keeps its value
`define QRS_ASSERT_HOLD(label, sig) \
	`QRS_ASSERT(label, !empty && !pop |=> $stable(sig), "held result changed")

`endif

// File: sv/qrs_pkg.sv
package qrs_pkg;

	// coefficient and root format
	localparam int DATA_WIDTH = 32;
	localparam int FRAC_BITS  = 16;

	// exact intermediate widths
	localparam int PROD_W    = 2 * DATA_WIDTH;
	localparam int DMAG_W    = 2 * DATA_WIDTH + 1;
	localparam int RAD_RAW_W = DMAG_W + 2 * FRAC_BITS;
	localparam int RAD_W     = RAD_RAW_W + (RAD_RAW_W % 2);
	localparam int SQ_STEPS  = RAD_W / 2;
	localparam int ROOT_W    = SQ_STEPS;
	localparam int REM_W     = ROOT_W + 2;
	localparam int NUM_W     = ROOT_W + 2;
	localparam int NMAG_W    = NUM_W - 1;
	localparam int T_W       = NMAG_W + 1;
	localparam int DIV_STEPS = T_W;
	localparam int DEN_W     = DATA_WIDTH + 1;
	localparam int DREM_W    = DEN_W + 1;

	// queue between front and back
	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);

	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_NOREAL = 2'd1,
		ST_AZERO  = 2'd2
	} status_t;

	// what the back needs of one classified item
	typedef struct packed {
		status_t                 status;
		logic                    a_neg;
		logic [DATA_WIDTH-1:0]   a_mag;
		logic                    b_neg;
		logic [DATA_WIDTH-1:0]   b_mag;
		logic                    d_neg;
	} meta_t;

	typedef struct packed {
		meta_t              meta;
		logic [DMAG_W-1:0]  dmag;
	} mid_t;

	typedef struct packed {
		logic [DATA_WIDTH-1:0] plus_real;
		logic [DATA_WIDTH-1:0] plus_imag;
		logic [DATA_WIDTH-1:0] minus_real;
		logic [DATA_WIDTH-1:0] minus_imag;
		status_t               status;
		logic                  sat;
	} out_t;

endpackage

// File: sv/quadratic_root_solver_core.sv
// quadratic roots of a, b, c in signed Q16.16, one coefficient set per cycle while full is low
// an accepted set passes the front stages, the queue, the square root and divider stages and the result buffer
// throughput: one item per cycle when nothing stalls, set by the 49-stage square root and 51-stage dividers
// a full result buffer stalls the back pipeline once a finished item waits; the front keeps filling a 4-deep queue
// reset (arst_n low, asynchronous) empties all stages and queues and clears the mode to 0
module quadratic_root_solver_core (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              push,
	output logic                              full,
	input  logic signed [qrs_pkg::DATA_WIDTH-1:0] coef_a,
	input  logic signed [qrs_pkg::DATA_WIDTH-1:0] coef_b,
	input  logic signed [qrs_pkg::DATA_WIDTH-1:0] coef_c,
	output logic                              empty,
	input  logic                              pop,
	output logic signed [qrs_pkg::DATA_WIDTH-1:0] plus_root_real,
	output logic signed [qrs_pkg::DATA_WIDTH-1:0] plus_root_imag,
	output logic signed [qrs_pkg::DATA_WIDTH-1:0] minus_root_real,
	output logic signed [qrs_pkg::DATA_WIDTH-1:0] minus_root_imag,
	output logic [1:0]                        status,
	output logic                              saturated,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic                              cfg_data
);
	import qrs_pkg::*;

	logic mode_q;
	logic q_push, q_full, q_pop, q_empty;
	mid_t q_wdata, q_rdata;
	out_t res;

	// mode register, written on each config transfer
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			mode_q <= cfg_data;
		end
	end

	qrs_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.full    (full),
		.coef_a  (coef_a),
		.coef_b  (coef_b),
		.coef_c  (coef_c),
		.mode    (mode_q),
		.q_push  (q_push),
		.q_wdata (q_wdata),
		.q_full  (q_full)
	);

	qrs_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  (q_wdata),
		.full   (q_full),
		.pop    (q_pop),
		.rdata  (q_rdata),
		.empty  (q_empty)
	);

	qrs_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_rdata (q_rdata),
		.q_empty (q_empty),
		.q_pop   (q_pop),
		.res     (res),
		.empty   (empty),
		.pop     (pop)
	);

	// result fields
	assign plus_root_real  = res.plus_real;
	assign plus_root_imag  = res.plus_imag;
	assign minus_root_real = res.minus_real;
	assign minus_root_imag = res.minus_imag;
	assign status          = res.status;
	assign saturated       = res.sat;

endmodule

// File: sv/qrs_front.sv
module qrs_front (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              push,
	output logic                              full,
	input  logic signed [qrs_pkg::DATA_WIDTH-1:0] coef_a,
	input  logic signed [qrs_pkg::DATA_WIDTH-1:0] coef_b,
	input  logic signed [qrs_pkg::DATA_WIDTH-1:0] coef_c,
	input  logic                              mode,
	output logic                              q_push,
	output qrs_pkg::mid_t                     q_wdata,
	input  logic                              q_full
);
	import qrs_pkg::*;

	logic v_s1, v_s2, v_s3;
	logic en;

	logic                  a_neg_s1, b_neg_s1, c_neg_s1, a_zero_s1;
	logic [DATA_WIDTH-1:0] a_mag_s1, b_mag_s1, c_mag_s1;

	logic                  a_neg_s2, b_neg_s2, diff_s2, a_zero_s2;
	logic [DATA_WIDTH-1:0] a_mag_s2, b_mag_s2;
	logic [PROD_W-1:0]     bb_s2, ac_s2;

	mid_t                  mid_s3;

	logic [DMAG_W-1:0]     p_ext, q4;
	logic                  d_neg;
	logic [DMAG_W-1:0]     dmag;
	status_t               st;

	// whole front moves together unless its last stage cannot transfer
	assign en     = !v_s3 || !q_full;
	assign full   = !en;
	assign q_push = v_s3 && en;
	assign q_wdata = mid_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= push;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// stage 1: sign and magnitude of each coefficient
	always_ff @(posedge clk) begin
		if (en) begin
			a_neg_s1  <= coef_a[DATA_WIDTH-1];
			b_neg_s1  <= coef_b[DATA_WIDTH-1];
			c_neg_s1  <= coef_c[DATA_WIDTH-1];
			a_zero_s1 <= (coef_a == '0);
			a_mag_s1  <= coef_a[DATA_WIDTH-1] ? (~coef_a + 1'b1) : coef_a;
			b_mag_s1  <= coef_b[DATA_WIDTH-1] ? (~coef_b + 1'b1) : coef_b;
			c_mag_s1  <= coef_c[DATA_WIDTH-1] ? (~coef_c + 1'b1) : coef_c;
		end
	end

	// stage 2: the two products
	always_ff @(posedge clk) begin
		if (en) begin
			bb_s2     <= PROD_W'(b_mag_s1) * PROD_W'(b_mag_s1);
			ac_s2     <= PROD_W'(a_mag_s1) * PROD_W'(c_mag_s1);
			diff_s2   <= a_neg_s1 ^ c_neg_s1;
			a_neg_s2  <= a_neg_s1;
			a_mag_s2  <= a_mag_s1;
			b_neg_s2  <= b_neg_s1;
			b_mag_s2  <= b_mag_s1;
			a_zero_s2 <= a_zero_s1;
		end
	end

	// discriminant as sign and magnitude, then classification
	always_comb begin
		p_ext = {1'b0, bb_s2};
		q4    = {ac_s2[PROD_W-2:0], 2'b00};
		if (diff_s2) begin
			dmag  = p_ext + q4;
			d_neg = 1'b0;
		end else if (p_ext >= q4) begin
			dmag  = p_ext - q4;
			d_neg = 1'b0;
		end else begin
			dmag  = q4 - p_ext;
			d_neg = 1'b1;
		end
		if (a_zero_s2) begin
			st = ST_AZERO;
		end else if (d_neg && mode) begin
			st = ST_NOREAL;
		end else begin
			st = ST_OK;
		end
	end

	// stage 3: classified item ready for the queue
	always_ff @(posedge clk) begin
		if (en) begin
			mid_s3.meta.status <= st;
			mid_s3.meta.a_neg  <= a_neg_s2;
			mid_s3.meta.a_mag  <= a_mag_s2;
			mid_s3.meta.b_neg  <= b_neg_s2;
			mid_s3.meta.b_mag  <= b_mag_s2;
			mid_s3.meta.d_neg  <= d_neg;
			mid_s3.dmag        <= dmag;
		end
	end

endmodule

// File: sv/qrs_queue.sv
module qrs_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  qrs_pkg::mid_t wdata,
	output logic          full,
	input  logic          pop,
	output qrs_pkg::mid_t rdata,
	output logic          empty
);
	import qrs_pkg::*;

	mid_t              mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_q, rd_q;
	logic [QPTR_W:0]   cnt_q;
	logic              do_push, do_pop;

	assign full    = (cnt_q == (QPTR_W+1)'(QDEPTH));
	assign empty   = (cnt_q == '0);
	assign rdata   = mem_q[rd_q];
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) wr_q <= wr_q + 1'b1;
			if (do_pop) rd_q <= rd_q + 1'b1;
			cnt_q <= cnt_q + (QPTR_W+1)'(do_push) - (QPTR_W+1)'(do_pop);
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (do_push) mem_q[wr_q] <= wdata;
	end

endmodule

// File: sv/qrs_back.sv
module qrs_back (
	input  logic          clk,
	input  logic          arst_n,
	input  qrs_pkg::mid_t q_rdata,
	input  logic          q_empty,
	output logic          q_pop,
	output qrs_pkg::out_t res,
	output logic          empty,
	input  logic          pop
);
	import qrs_pkg::*;

	typedef struct packed {
		meta_t             meta;
		logic [RAD_W-1:0]  rad;
		logic [REM_W-1:0]  rem;
		logic [ROOT_W-1:0] root;
	} sq_t;

	typedef struct packed {
		meta_t             meta;
		logic              n0_neg;
		logic              n1_neg;
		logic [DEN_W-1:0]  den;
		logic [T_W-1:0]    t0;
		logic [T_W-1:0]    t1;
		logic [DREM_W-1:0] r0;
		logic [DREM_W-1:0] r1;
		logic [T_W-1:0]    q0;
		logic [T_W-1:0]    q1;
	} dv_t;

	typedef struct packed {
		logic [DATA_WIDTH-1:0] v;
		logic                  sat;
	} code_t;

	// one bit of the square root
	function automatic sq_t sq_step(input sq_t x);
		logic [REM_W-1:0] rsh;
		logic [REM_W-1:0] trial;
		sq_t              y;
		rsh   = {x.rem[REM_W-3:0], x.rad[RAD_W-1 -: 2]};
		trial = {x.root, 2'b01};
		y      = x;
		y.rad  = {x.rad[RAD_W-3:0], 2'b00};
		if (rsh >= trial) begin
			y.rem  = rsh - trial;
			y.root = {x.root[ROOT_W-2:0], 1'b1};
		end else begin
			y.rem  = rsh;
			y.root = {x.root[ROOT_W-2:0], 1'b0};
		end
		return y;
	endfunction

	// both numerators from -b and the root, offset by |a| for rounding
	function automatic dv_t dv_init(input sq_t x);
		logic [NUM_W-1:0] bext, nbv, sv, n0, n1, m0, m1;
		dv_t              y;
		bext = NUM_W'(x.meta.b_mag) << FRAC_BITS;
		nbv  = x.meta.b_neg ? bext : (~bext + 1'b1);
		sv   = NUM_W'(x.root);
		if (x.meta.d_neg) begin
			n0 = nbv;
			n1 = sv;
		end else begin
			n0 = nbv + sv;
			n1 = nbv - sv;
		end
		m0 = n0[NUM_W-1] ? (~n0 + 1'b1) : n0;
		m1 = n1[NUM_W-1] ? (~n1 + 1'b1) : n1;
		y.meta   = x.meta;
		y.n0_neg = n0[NUM_W-1];
		y.n1_neg = n1[NUM_W-1];
		y.den    = {x.meta.a_mag, 1'b0};
		y.t0     = T_W'(m0[NMAG_W-1:0]) + T_W'(x.meta.a_mag);
		y.t1     = T_W'(m1[NMAG_W-1:0]) + T_W'(x.meta.a_mag);
		y.r0     = '0;
		y.r1     = '0;
		y.q0     = '0;
		y.q1     = '0;
		return y;
	endfunction

	// one quotient bit of both restoring dividers
	function automatic dv_t dv_step(input dv_t x);
		logic [DREM_W-1:0] r0, r1, d;
		dv_t               y;
		d  = DREM_W'(x.den);
		r0 = {x.r0[DREM_W-2:0], x.t0[T_W-1]};
		r1 = {x.r1[DREM_W-2:0], x.t1[T_W-1]};
		y    = x;
		y.t0 = {x.t0[T_W-2:0], 1'b0};
		y.t1 = {x.t1[T_W-2:0], 1'b0};
		if (r0 >= d) begin
			y.r0 = r0 - d;
			y.q0 = {x.q0[T_W-2:0], 1'b1};
		end else begin
			y.r0 = r0;
			y.q0 = {x.q0[T_W-2:0], 1'b0};
		end
		if (r1 >= d) begin
			y.r1 = r1 - d;
			y.q1 = {x.q1[T_W-2:0], 1'b1};
		end else begin
			y.r1 = r1;
			y.q1 = {x.q1[T_W-2:0], 1'b0};
		end
		return y;
	endfunction

	// signed, saturated root code from a quotient magnitude
	function automatic code_t sat_code(input logic [T_W-1:0] q, input logic neg);
		logic [T_W-1:0] lim, qq;
		logic           n;
		code_t          c;
		n   = neg && (q != '0);
		lim = n ? (T_W'(1) << (DATA_WIDTH - 1)) : ((T_W'(1) << (DATA_WIDTH - 1)) - 1'b1);
		c.sat = (q > lim);
		qq    = c.sat ? lim : q;
		c.v   = n ? (~qq[DATA_WIDTH-1:0] + 1'b1) : qq[DATA_WIDTH-1:0];
		return c;
	endfunction

	sq_t  sq_s   [SQ_STEPS+1];
	logic sq_v_s [SQ_STEPS+1];
	dv_t  dv_s   [DIV_STEPS+1];
	logic dv_v_s [DIV_STEPS+1];

	logic en;
	logic ofull;
	logic opush;

	// pipeline holds only when its finished item cannot transfer
	assign en    = !(dv_v_s[DIV_STEPS] && ofull);
	assign q_pop = en && !q_empty;
	assign opush = en && dv_v_s[DIV_STEPS];

	// load from the queue
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sq_v_s[0] <= 1'b0;
			dv_v_s[0] <= 1'b0;
		end else if (en) begin
			sq_v_s[0] <= q_pop;
			dv_v_s[0] <= sq_v_s[SQ_STEPS];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sq_s[0].meta <= q_rdata.meta;
			sq_s[0].rad  <= RAD_W'(q_rdata.dmag) << (2 * FRAC_BITS);
			sq_s[0].rem  <= '0;
			sq_s[0].root <= '0;
			dv_s[0]      <= dv_init(sq_s[SQ_STEPS]);
		end
	end

	// square root stages
	for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sq
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				sq_v_s[k+1] <= 1'b0;
			end else if (en) begin
				sq_v_s[k+1] <= sq_v_s[k];
			end
		end
		always_ff @(posedge clk) begin
			if (en) sq_s[k+1] <= sq_step(sq_s[k]);
		end
	end

	// divider stages
	for (genvar k = 0; k < DIV_STEPS; k++) begin : g_dv
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_v_s[k+1] <= 1'b0;
			end else if (en) begin
				dv_v_s[k+1] <= dv_v_s[k];
			end
		end
		always_ff @(posedge clk) begin
			if (en) dv_s[k+1] <= dv_step(dv_s[k]);
		end
	end

	// result assembly per case
	dv_t   last;
	code_t c0, c1, cpi, cmi;
	out_t  ores;

	always_comb begin
		last = dv_s[DIV_STEPS];
		c0   = sat_code(last.q0, last.n0_neg ^ last.meta.a_neg);
		c1   = sat_code(last.q1, last.n1_neg ^ last.meta.a_neg);
		cpi  = sat_code(last.q1, last.meta.a_neg);
		cmi  = sat_code(last.q1, !last.meta.a_neg);
		ores.status = last.meta.status;
		if (last.meta.status != ST_OK) begin
			ores.plus_real  = '0;
			ores.plus_imag  = '0;
			ores.minus_real = '0;
			ores.minus_imag = '0;
			ores.sat        = 1'b0;
		end else if (!last.meta.d_neg) begin
			ores.plus_real  = c0.v;
			ores.plus_imag  = '0;
			ores.minus_real = c1.v;
			ores.minus_imag = '0;
			ores.sat        = c0.sat | c1.sat;
		end else begin
			ores.plus_real  = c0.v;
			ores.plus_imag  = cpi.v;
			ores.minus_real = c0.v;
			ores.minus_imag = cmi.v;
			ores.sat        = c0.sat | cpi.sat | cmi.sat;
		end
	end

	// two-entry result buffer
	out_t       obuf_q [2];
	logic       owr_q, ord_q;
	logic [1:0] ocnt_q;
	logic       odo_pop;

	assign ofull   = (ocnt_q == 2'd2);
	assign empty   = (ocnt_q == 2'd0);
	assign res     = obuf_q[ord_q];
	assign odo_pop = pop && !empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			owr_q  <= 1'b0;
			ord_q  <= 1'b0;
			ocnt_q <= 2'd0;
		end else begin
			if (opush) owr_q <= ~owr_q;
			if (odo_pop) ord_q <= ~ord_q;
			ocnt_q <= ocnt_q + 2'(opush) - 2'(odo_pop);
		end
	end

	always_ff @(posedge clk) begin
		if (opush) obuf_q[owr_q] <= ores;
	end

endmodule

// File: sv/qrs_checker.sv
`include "quadratic_root_solver_core_macros.svh"

module qrs_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              empty,
	input logic                              pop,
	input logic signed [qrs_pkg::DATA_WIDTH-1:0] plus_root_real,
	input logic signed [qrs_pkg::DATA_WIDTH-1:0] plus_root_imag,
	input logic signed [qrs_pkg::DATA_WIDTH-1:0] minus_root_real,
	input logic signed [qrs_pkg::DATA_WIDTH-1:0] minus_root_imag,
	input logic [1:0]                        status,
	input logic                              saturated
);
	import qrs_pkg::*;

	// a flagged status carries zero roots and no clipping
	`QRS_ASSERT(a_flag_zero, !empty && status != ST_OK |-> plus_root_real == 0 && plus_root_imag == 0 && minus_root_real == 0 && minus_root_imag == 0 && !saturated, "flagged result not zero")

	// unclipped imaginary parts form a conjugate pair
	`QRS_ASSERT(a_conjugate, !empty && status == ST_OK && !saturated |-> plus_root_imag == -minus_root_imag, "imaginary parts not conjugate")

	// complex roots share their real part
	`QRS_ASSERT(a_real_shared, !empty && plus_root_imag != 0 |-> plus_root_real == minus_root_real, "complex pair real parts differ")

	// waiting result does not change before its transfer
	`QRS_ASSERT_HOLD(a_hold_real, plus_root_real)

endmodule

bind quadratic_root_solver_core qrs_checker u_qrs_checker (.*);
